### sv/mid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mid_pkg;
   // Width of the box length register.
   localparam int BOX_WIDTH = 31;
   // Width of the distance result.
   localparam int DIST_WIDTH = 33;
endpackage
`default_nettype wire

### sv/min_image_distance_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    first_x/y/z, second_x/y/z
// rsp_      out        rsp_valid/rsp_ready    distance
// csr_      in         csr_write_enable       box_length (no wait, no read-back)
//
// One transfer is accepted every cycle unless a result waits with rsp_ready low.
// The delay to rsp_valid is set by the bit-per-stage remainder
// (COORD_WIDTH+1 stages) and the bit-per-stage square root (COORD_WIDTH+3 stages),
// plus the magnitude, fold, square, sum and output registers.
// Reset clears the valid bits and the box length (wrapping off).
// When a result waits and rsp_ready is low the whole pipeline holds; items in
// flight keep their places and nothing is lost or repeated.
module min_image_distance_3d #(
   parameter int COORD_WIDTH = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  signed [COORD_WIDTH-1:0]     req_first_x,
   input  wire  signed [COORD_WIDTH-1:0]     req_first_y,
   input  wire  signed [COORD_WIDTH-1:0]     req_first_z,
   input  wire  signed [COORD_WIDTH-1:0]     req_second_x,
   input  wire  signed [COORD_WIDTH-1:0]     req_second_y,
   input  wire  signed [COORD_WIDTH-1:0]     req_second_z,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [mid_pkg::DIST_WIDTH-1:0]    rsp_distance,
   input  wire                               csr_write_enable,
   input  wire  [mid_pkg::BOX_WIDTH-1:0]     csr_box_length
);
   localparam int MW   = COORD_WIDTH + 1;        // axis magnitude width
   localparam int SQW  = 2 * MW;                 // one square
   localparam int SW   = 2 * MW + 2;             // sum of three squares
   localparam int RTW  = COORD_WIDTH + 3;        // root width
   localparam int TW   = 2 * COORD_WIDTH + 6;    // root trial width
   localparam int LAX  = MW + 2;                 // axis unit latency
   localparam int NST  = LAX + 2 + RTW + 1;      // total stages
   localparam int DW   = mid_pkg::DIST_WIDTH;
   localparam int OW   = RTW + DW;

   logic [mid_pkg::BOX_WIDTH-1:0] box_ff;
   logic [NST-1:0]                vld_ff;
   logic                          en;
   logic [MW-1:0]                 dx, dy, dz;
   logic [SQW-1:0]                sqx_ff, sqy_ff, sqz_ff;
   logic [SW-1:0]                 sum_ff;
   logic [RTW-1:0]                rt_ff [RTW];
   logic [TW-1:0]                 rm_ff [RTW];
   logic [OW-1:0]                 root_x;
   logic [DW-1:0]                 dist_in;
   logic [DW-1:0]                 dist_ff;

   // The pipeline advances unless a finished result waits at the output.
   assign en        = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NST-1];
   assign rsp_distance = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else if (csr_write_enable) begin
         box_ff <= csr_box_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   mid_axis_wrap #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
      .clock(clock), .en(en), .box(box_ff),
      .coord_a(req_first_x), .coord_b(req_second_x), .mag_out(dx));
   mid_axis_wrap #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
      .clock(clock), .en(en), .box(box_ff),
      .coord_a(req_first_y), .coord_b(req_second_y), .mag_out(dy));
   mid_axis_wrap #(.COORD_WIDTH(COORD_WIDTH)) u_axis_z (
      .clock(clock), .en(en), .box(box_ff),
      .coord_a(req_first_z), .coord_b(req_second_z), .mag_out(dz));

   // Squares, then their sum, each in a stage of its own.
   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= SQW'(dx) * SQW'(dx);
         sqy_ff <= SQW'(dy) * SQW'(dy);
         sqz_ff <= SQW'(dz) * SQW'(dz);
         sum_ff <= SW'(sqx_ff) + SW'(sqy_ff) + SW'(sqz_ff);
      end
   end

   // Square root, one result bit per stage from the top. The remainder holds
   // sum minus root squared; setting bit k adds (root << (k+1)) + 2^(2k).
   genvar s;
   generate
      for (s = 0; s < RTW; s++) begin : g_sqrt
         localparam int K = RTW - 1 - s;
         logic [RTW-1:0] rt_prev;
         logic [TW-1:0]  rm_prev;
         logic [TW-1:0]  trial;
         if (s == 0) begin : g_first
            assign rt_prev = '0;
            assign rm_prev = TW'(sum_ff);
         end else begin : g_next
            assign rt_prev = rt_ff[s-1];
            assign rm_prev = rm_ff[s-1];
         end
         assign trial = (TW'(rt_prev) << (K + 1)) + (TW'(1) << (2 * K));
         always_ff @(posedge clock) begin
            if (en) begin
               if (rm_prev >= trial) begin
                  rm_ff[s] <= rm_prev - trial;
                  rt_ff[s] <= rt_prev | (RTW'(1) << K);
               end else begin
                  rm_ff[s] <= rm_prev;
                  rt_ff[s] <= rt_prev;
               end
            end
         end
      end
   endgenerate

   // Saturate to the result width for wide coordinates.
   always_comb begin
      root_x = OW'(rt_ff[RTW-1]);
      if (root_x > OW'({DW{1'b1}})) begin
         dist_in = {DW{1'b1}};
      end else begin
         dist_in = root_x[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
      end
   end
endmodule
`default_nettype wire

### sv/mid_axis_wrap.sv
`timescale 1ns / 1ps
`default_nettype none
// One axis: magnitude of the difference, a pipelined restoring remainder by
// the box length (one quotient bit per stage) and the fold to the nearest image.
module mid_axis_wrap #(
   parameter int COORD_WIDTH = 32
) (
   input  wire                                  clock,
   input  wire                                  en,
   input  wire  [mid_pkg::BOX_WIDTH-1:0]        box,
   input  wire  signed [COORD_WIDTH-1:0]        coord_a,
   input  wire  signed [COORD_WIDTH-1:0]        coord_b,
   output logic [COORD_WIDTH:0]                 mag_out
);
   localparam int MW = COORD_WIDTH + 1;
   localparam int RW = mid_pkg::BOX_WIDTH + 1;
   localparam int XW = MW + RW;

   logic signed [MW-1:0] diff;
   logic [MW-1:0]        mag_in;
   logic [MW-1:0]        mag_ff;
   logic [MW-1:0]        mg_ff [MW];
   logic [RW-1:0]        rm_ff [MW];
   logic [MW-1:0]        wrap_in;
   logic [MW-1:0]        wrap_ff;
   logic [XW-1:0]        rx;
   logic [XW-1:0]        bx;

   always_comb begin
      diff   = MW'(coord_a) - MW'(coord_b);
      mag_in = diff[MW-1] ? MW'(-diff) : MW'(diff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
      end
   end

   genvar j;
   generate
      for (j = 0; j < MW; j++) begin : g_div
         logic [MW-1:0] mg_prev;
         logic [RW-1:0] rm_prev;
         logic [RW-1:0] shifted;
         logic [RW-1:0] rm_in;
         if (j == 0) begin : g_first
            assign mg_prev = mag_ff;
            assign rm_prev = '0;
         end else begin : g_next
            assign mg_prev = mg_ff[j-1];
            assign rm_prev = rm_ff[j-1];
         end
         always_comb begin
            shifted = {rm_prev[RW-2:0], mg_prev[MW-1-j]};
            if (box != '0 && shifted >= RW'(box)) begin
               rm_in = shifted - RW'(box);
            end else begin
               rm_in = shifted;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               mg_ff[j] <= mg_prev;
               rm_ff[j] <= rm_in;
            end
         end
      end
   endgenerate

   always_comb begin
      rx = XW'(rm_ff[MW-1]);
      bx = XW'(box);
      if (box == '0) begin
         wrap_in = mg_ff[MW-1];
      end else if ((rx << 1) > bx) begin
         wrap_in = MW'(bx - rx);
      end else begin
         wrap_in = MW'(rx);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wrap_ff <= wrap_in;
      end
   end

   assign mag_out = wrap_ff;
endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   // One row of the directed table. When known is set, the distance is typed
   // in; otherwise the predictor supplies it.
   typedef struct {
      logic [mid_pkg::BOX_WIDTH-1:0]  box;
      logic [31:0]                    fx, fy, fz, sx, sy, sz;
      bit                             known;
      logic [mid_pkg::DIST_WIDTH-1:0] known_dist;
   } pair_row_type;

   localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] C_MIN = 32'h8000_0000;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [mid_pkg::BOX_WIDTH-1:0] BOX_OFF = '0;
   localparam logic [mid_pkg::BOX_WIDTH-1:0] BOX_TWO = 31'h0002_0000;
   localparam logic [mid_pkg::BOX_WIDTH-1:0] BOX_TOP = 31'h7FFF_FFFF;
   localparam int LATENCY = 2 * 32 + 8;
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_first_x = '0, req_first_y = '0, req_first_z = '0;
   logic [31:0] req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [mid_pkg::DIST_WIDTH-1:0] rsp_distance;
   logic csr_write_enable = 1'b0;
   logic [mid_pkg::BOX_WIDTH-1:0] csr_box_length = '0;

   // Box length as the block should currently hold it.
   logic [mid_pkg::BOX_WIDTH-1:0] box_now = '0;
   logic [mid_pkg::DIST_WIDTH-1:0] pending_dist[$];
   int  failures = 0;
   int  idle_cycles = 0;
   // While calm is set, neither side inserts gaps.
   bit  calm = 1'b0;

   always #10 clock = ~clock;

   min_image_distance_3d DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_first_x(req_first_x), .req_first_y(req_first_y), .req_first_z(req_first_z),
      .req_second_x(req_second_x), .req_second_y(req_second_y),
      .req_second_z(req_second_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_distance(rsp_distance),
      .csr_write_enable(csr_write_enable), .csr_box_length(csr_box_length)
   );

   // Magnitude of the wrapped difference along one axis. The difference is
   // taken at full precision, then reduced to the nearest image; an exact
   // half box keeps its magnitude because halves round toward zero.
   function automatic logic [71:0] wrapped_gap(logic [31:0] a, logic [31:0] b,
                                              logic [mid_pkg::BOX_WIDTH-1:0] box);
      longint d;
      logic [71:0] m, r;
      d = longint'($signed(a)) - longint'($signed(b));
      m = (d < 0) ? 72'(-d) : 72'(d);
      if (box != 0) begin
         r = m % box;
         m = (2 * r > box) ? box - r : r;
      end
      return m;
   endfunction

   // Floored square root of the sum of the squared wrapped differences.
   function automatic logic [mid_pkg::DIST_WIDTH-1:0] image_distance(
         logic [31:0] fx, fy, fz, sx, sy, sz, logic [mid_pkg::BOX_WIDTH-1:0] box);
      logic [71:0] dx, dy, dz, sum, root, cand;
      dx = wrapped_gap(fx, sx, box);
      dy = wrapped_gap(fy, sy, box);
      dz = wrapped_gap(fz, sz, box);
      sum = dx * dx + dy * dy + dz * dz;
      root = '0;
      for (int bit_pos = 34; bit_pos >= 0; bit_pos--) begin
         cand = root | (72'd1 << bit_pos);
         if (cand * cand <= sum) root = cand;
      end
      return (root > 72'h1_FFFF_FFFF) ? '1 : root[mid_pkg::DIST_WIDTH-1:0];
   endfunction

   // Draws a random gap length: mostly none, some short, a few long.
   function automatic int gap_length();
      int pick;
      if (calm) return 0;
      pick = $urandom_range(99);
      if (pick < 55) return 0;
      if (pick < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Offers one point pair and waits for its transfer. The expectation is
   // queued at the edge where the transfer happens.
   task automatic offer_pair(pair_row_type row);
      req_first_x  <= row.fx;
      req_first_y  <= row.fy;
      req_first_z  <= row.fz;
      req_second_x <= row.sx;
      req_second_y <= row.sy;
      req_second_z <= row.sz;
      req_valid    <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_dist.push_back(row.known ? row.known_dist :
         image_distance(row.fx, row.fy, row.fz, row.sx, row.sy, row.sz, box_now));
   endtask

   // Sends a pair, then possibly drops valid for a random gap from gap_length.
   task automatic send_pair(pair_row_type row);
      int gap;
      offer_pair(row);
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Changes the box length once the pipeline has emptied. Every pair yields
   // a result, so an empty expectation queue means nothing is in flight.
   task automatic set_box(logic [mid_pkg::BOX_WIDTH-1:0] box);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_dist.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_box_length   <= box;
      box_now = box;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_box_length   <= 31'($urandom);
   endtask

   // A random coordinate pair along one axis, biased toward the interesting
   // regions: near image boundaries, exact half boxes and the extremes.
   task automatic random_axis(logic [mid_pkg::BOX_WIDTH-1:0] box,
                              output logic [31:0] a, output logic [31:0] b);
      int pick;
      longint span, d;
      pick = $urandom_range(99);
      span = (box == 0) ? 64'd1 << 20 : longint'(box);
      a = $urandom;
      if (pick < 40) begin
         b = $urandom;
      end else if (pick < 70) begin
         d = longint'($urandom_range(8)) * span / 2 - 2 * span
             + longint'($urandom_range(16)) - 8;
         b = 32'(longint'($signed(a)) - d);
      end else if (pick < 85) begin
         d = longint'($urandom_range(4)) * span + span / 2;
         if ($urandom_range(1)) d = -d;
         b = 32'(longint'($signed(a)) - d);
      end else begin
         a = $urandom_range(1) ? C_MAX : C_MIN;
         b = $urandom_range(1) ? C_MAX : C_MIN;
      end
   endtask

   pair_row_type directed[$];

   initial begin
      pair_row_type row;
      logic [mid_pkg::BOX_WIDTH-1:0] box_plan[8];
      directed = '{
         // Wrapping off: plain Euclidean distance.
         '{BOX_OFF, 0, 0, 0, 0, 0, 0, 1, 33'd0},
         '{BOX_OFF, ONE, 0, 0, 0, 0, 0, 1, 33'h1_0000},
         '{BOX_OFF, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 1, 33'h5_0000},
         '{BOX_OFF, C_MAX, 0, 0, C_MIN, 0, 0, 1, 33'hFFFF_FFFF},
         '{BOX_OFF, 0, C_MIN, 0, 0, C_MAX, 0, 1, 33'hFFFF_FFFF},
         '{BOX_OFF, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 0, 0},
         '{BOX_OFF, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1, 33'd0},
         '{BOX_OFF, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321,
           32'h0000_0001, 32'hEDCB_A987, 32'h789A_BCDE, 0, 0},
         // Box of 2.0: exact halves keep half a box, whole boxes vanish.
         '{BOX_TWO, ONE, 0, 0, 0, 0, 0, 1, 33'h1_0000},
         '{BOX_TWO, 3 * ONE, 0, 0, 0, 0, 0, 1, 33'h1_0000},
         '{BOX_TWO, 0, 0, 0, 0, 0, 3 * ONE, 1, 33'h1_0000},
         '{BOX_TWO, 0, 2 * ONE, 0, 0, 0, 0, 1, 33'd0},
         '{BOX_TWO, 32'h0003_0D40, 32'hFFFE_0001, 32'h0001_8001, 0, 0, 0, 0, 0},
         // Largest box: a full-range difference is two boxes plus one LSB.
         '{BOX_TOP, C_MAX, 0, 0, C_MIN, 0, 0, 1, 33'd1},
         '{BOX_TOP, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0, 0},
         '{BOX_TOP, 32'h3FFF_FFFF, 0, 0, 32'hC000_0000, 0, 0, 0, 0},
         // Smallest box: every point is its own image.
         '{31'd1, C_MAX, C_MIN, 32'h1234_5678, 0, C_MAX, 32'hFFFF_FFFF, 1, 33'd0}
      };
      box_plan = '{BOX_OFF, 31'd1, 31'd3, 31'h0001_0000, BOX_TOP, 31'h4000_0000,
                   31'h00A0_0001, 31'(($urandom | 1) >> 1)};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].box != box_now) set_box(directed[i].box);
         send_pair(directed[i]);
      end

      // Random phases, one per box length, each of 180 pairs.
      foreach (box_plan[p]) begin
         set_box(box_plan[p]);
         calm = (p % 3 == 2);
         for (int n = 0; n < 180; n++) begin
            random_axis(box_now, row.fx, row.sx);
            random_axis(box_now, row.fy, row.sy);
            random_axis(box_now, row.fz, row.sz);
            row.known = 1'b0;
            row.box = box_now;
            send_pair(row);
         end
         calm = 1'b0;
      end

      req_valid <= 1'b0;
      while (pending_dist.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Result side: ready high or low in runs, sometimes long stalls.
   int ready_hold = 0;
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         if (!rsp_ready || $urandom_range(1)) begin
            rsp_ready  <= 1'b1;
            ready_hold <= $urandom_range(30, 1);
         end else begin
            rsp_ready  <= 1'b0;
            ready_hold <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                  : $urandom_range(3);
         end
      end
   end

   // Every result transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      logic [mid_pkg::DIST_WIDTH-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dist.size() == 0) begin
            $display("%0t: distance %h with no pair outstanding", $time, rsp_distance);
            failures++;
         end else begin
            want = pending_dist.pop_front();
            if (rsp_distance !== want) begin
               $display("%0t: distance expected %h actual %h", $time, want, rsp_distance);
               failures++;
            end
         end
      end
   end

   // Ends the run if neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire
